// File: sv/c8ie_pkg.sv
// ----------------------------------------------------------------------------
// c8ie_pkg
// Shared types and constants for the instruction execute block.
// ----------------------------------------------------------------------------
package c8ie_pkg;

    localparam int MEMORY_BYTES  = 4096;
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int PROGRAM_START = 512;

    localparam int AW = 12;
    localparam int RW = 5;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_STEP  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [3:0] GRP_SYS  = 4'h0;
    localparam logic [3:0] GRP_JUMP = 4'h1;
    localparam logic [3:0] GRP_SET  = 4'h6;
    localparam logic [3:0] GRP_ADD  = 4'h7;
    localparam logic [3:0] GRP_IDX  = 4'hA;
    localparam logic [3:0] GRP_DRAW = 4'hD;
    localparam logic [11:0] NNN_CLS = 12'h0E0;
    localparam logic [3:0] REG_VF   = 4'hF;

    typedef struct packed {
        logic [1:0]    cmd;
        logic [AW-1:0] addr;
        logic [7:0]    data;
    } t_req;

    typedef struct packed {
        logic [AW-1:0] pc_after;
        logic          collision;
        logic          unknown_op;
        logic [63:0]   row_pixels;
    } t_rsp;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FETCH0, ST_FETCH1, ST_FETCH2, ST_EXEC,
        ST_DRAW_RD, ST_DRAW_WT, ST_DRAW_UPD, ST_CLEAR, ST_ROW_RD, ST_ROW_WT, ST_DONE
    } t_state;

endpackage

// File: sv/c8ie_front.sv
// ----------------------------------------------------------------------------
// c8ie_front
// Input stage: accepts requests into a two-entry queue for the executor.
// ----------------------------------------------------------------------------
module c8ie_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  c8ie_pkg::t_req  i_req,
    output logic            o_valid,
    input  logic            i_ready,
    output c8ie_pkg::t_req  o_req
);
    c8ie_pkg::t_req r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= i_req;
    end
endmodule

// File: sv/c8ie_back.sv
// ----------------------------------------------------------------------------
// c8ie_back
// Executor: memory, display, registers and the sequencer that runs commands.
// ----------------------------------------------------------------------------
module c8ie_back #(
    parameter int PROGRAM_START = c8ie_pkg::PROGRAM_START
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  c8ie_pkg::t_req  i_req,
    output logic            o_valid,
    input  logic            i_ready,
    output c8ie_pkg::t_rsp  o_rsp
);
    localparam int AW = c8ie_pkg::AW;
    localparam int RW = c8ie_pkg::RW;

    logic [7:0]    r_mem [c8ie_pkg::MEMORY_BYTES];
    logic [63:0]   r_scr [c8ie_pkg::SCREEN_HEIGHT];
    logic [c8ie_pkg::SCREEN_HEIGHT-1:0] r_scr_vld;
    logic [7:0]    r_v [16];
    logic [AW-1:0] r_i, r_pc;

    c8ie_pkg::t_state r_st, n_st;
    c8ie_pkg::t_req   r_req;
    logic [15:0]   r_w;
    logic [7:0]    r_mdat;
    logic [63:0]   r_sdat;
    logic          r_svld;
    logic [5:0]    r_xs;
    logic [RW-1:0] r_row;
    logic [3:0]    r_cnt;
    logic          r_hit;
    logic          r_ovld;
    c8ie_pkg::t_rsp r_rsp;

    logic [AW-1:0] w_maddr;
    logic [RW-1:0] w_raddr;
    logic [63:0]   w_bits, w_cur;

    assign o_ready = (r_st == c8ie_pkg::ST_IDLE) && !r_ovld;
    assign o_valid = r_ovld;
    assign o_rsp   = r_rsp;
    assign w_bits  = {r_mdat, 56'd0} >> r_xs;
    assign w_cur   = r_svld ? r_sdat : 64'd0;

    always_comb begin
        case (r_st)
            c8ie_pkg::ST_FETCH0:  w_maddr = r_pc;
            c8ie_pkg::ST_FETCH1:  w_maddr = r_pc + AW'(1);
            default:              w_maddr = r_i + AW'(r_cnt);
        endcase
        w_raddr = (r_st == c8ie_pkg::ST_ROW_RD) ? r_req.addr[RW-1:0] : r_row;
    end

    always_ff @(posedge i_clk) begin
        r_mdat <= r_mem[w_maddr];
        r_sdat <= r_scr[w_raddr];
        r_svld <= r_scr_vld[w_raddr];
        if (o_ready && i_valid && i_req.cmd == c8ie_pkg::CMD_WRITE)
            r_mem[i_req.addr] <= i_req.data;
        if (r_st == c8ie_pkg::ST_DRAW_UPD)
            r_scr[r_row] <= w_cur ^ w_bits;
        if (r_st == c8ie_pkg::ST_FETCH1) r_w[15:8] <= r_mdat;
        if (r_st == c8ie_pkg::ST_FETCH2) r_w[7:0]  <= r_mdat;
        if (o_ready && i_valid) r_req <= i_req;
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            c8ie_pkg::ST_IDLE:
                if (o_ready && i_valid) begin
                    case (i_req.cmd)
                        c8ie_pkg::CMD_STEP: n_st = c8ie_pkg::ST_FETCH0;
                        c8ie_pkg::CMD_READ: n_st = c8ie_pkg::ST_ROW_RD;
                        default:            n_st = c8ie_pkg::ST_DONE;
                    endcase
                end
            c8ie_pkg::ST_FETCH0:   n_st = c8ie_pkg::ST_FETCH1;
            c8ie_pkg::ST_FETCH1:   n_st = c8ie_pkg::ST_FETCH2;
            c8ie_pkg::ST_FETCH2:   n_st = c8ie_pkg::ST_EXEC;
            c8ie_pkg::ST_EXEC:
                if (r_w[15:12] == c8ie_pkg::GRP_DRAW && r_w[3:0] != 4'd0)
                    n_st = c8ie_pkg::ST_DRAW_RD;
                else
                    n_st = c8ie_pkg::ST_DONE;
            c8ie_pkg::ST_DRAW_RD:  n_st = c8ie_pkg::ST_DRAW_WT;
            c8ie_pkg::ST_DRAW_WT:  n_st = c8ie_pkg::ST_DRAW_UPD;
            c8ie_pkg::ST_DRAW_UPD:
                if (r_cnt + 4'd1 == r_w[3:0] || r_row == RW'(c8ie_pkg::SCREEN_HEIGHT - 1))
                    n_st = c8ie_pkg::ST_DONE;
                else
                    n_st = c8ie_pkg::ST_DRAW_RD;
            c8ie_pkg::ST_ROW_RD:   n_st = c8ie_pkg::ST_ROW_WT;
            c8ie_pkg::ST_ROW_WT:   n_st = c8ie_pkg::ST_DONE;
            c8ie_pkg::ST_DONE:     n_st = c8ie_pkg::ST_IDLE;
            default:               n_st = c8ie_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= c8ie_pkg::ST_IDLE;
            r_ovld    <= 1'b0;
            r_scr_vld <= '0;
            r_i       <= '0;
            r_pc      <= AW'(PROGRAM_START);
            for (int k = 0; k < 16; k++) r_v[k] <= 8'd0;
        end else begin
            r_st <= n_st;
            if (r_ovld && i_ready) r_ovld <= 1'b0;
            case (r_st)
                c8ie_pkg::ST_IDLE: begin
                    if (o_ready && i_valid) begin
                        r_hit <= 1'b0;
                        r_rsp <= '0;
                    end
                end
                c8ie_pkg::ST_FETCH2: r_pc <= r_pc + AW'(2);
                c8ie_pkg::ST_EXEC: begin
                    r_cnt <= 4'd0;
                    r_xs  <= r_v[r_w[11:8]][5:0];
                    r_row <= r_v[r_w[7:4]][RW-1:0];
                    case (r_w[15:12])
                        c8ie_pkg::GRP_SYS:
                            if (r_w[11:0] == c8ie_pkg::NNN_CLS) r_scr_vld <= '0;
                            else r_rsp.unknown_op <= 1'b1;
                        c8ie_pkg::GRP_JUMP: r_pc <= r_w[11:0];
                        c8ie_pkg::GRP_SET:  r_v[r_w[11:8]] <= r_w[7:0];
                        c8ie_pkg::GRP_ADD:  r_v[r_w[11:8]] <= r_v[r_w[11:8]] + r_w[7:0];
                        c8ie_pkg::GRP_IDX:  r_i <= r_w[11:0];
                        c8ie_pkg::GRP_DRAW: r_v[c8ie_pkg::REG_VF] <= 8'd0;
                        default:            r_rsp.unknown_op <= 1'b1;
                    endcase
                end
                c8ie_pkg::ST_DRAW_UPD: begin
                    r_scr_vld[r_row] <= 1'b1;
                    if ((w_cur & w_bits) != 64'd0) begin
                        r_hit <= 1'b1;
                        r_v[c8ie_pkg::REG_VF] <= 8'd1;
                    end
                    r_cnt <= r_cnt + 4'd1;
                    r_row <= r_row + RW'(1);
                end
                c8ie_pkg::ST_ROW_WT: r_rsp.row_pixels <= w_cur;
                c8ie_pkg::ST_DONE: begin
                    r_rsp.pc_after  <= r_pc;
                    r_rsp.collision <= r_hit;
                    r_ovld          <= 1'b1;
                end
                default: ;
            endcase
        end
    end
endmodule

// File: sv/chip8_instruction_execute.sv
// ----------------------------------------------------------------------------
// chip8_instruction_execute
// Executes a small instruction subset over a 4 KiB memory and 64x32 display.
// ----------------------------------------------------------------------------
// Requests enter a two-entry queue and run one at a time in the executor. A
// step fetches the two instruction bytes from memory and then executes; a
// draw then reads, waits on and updates each sprite row in turn. Results sit
// in an output register until taken.
module chip8_instruction_execute #(
    parameter int PROGRAM_START = c8ie_pkg::PROGRAM_START
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // cmd[1:0], addr[13:2], data[21:14]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata   // pc_after, collision, unknown_op, row_pixels
);
    c8ie_pkg::t_req w_in, w_q;
    c8ie_pkg::t_rsp w_rsp;
    logic           w_qv, w_qr;

    assign w_in.cmd  = s_axis_tdata[1:0];
    assign w_in.addr = s_axis_tdata[13:2];
    assign w_in.data = s_axis_tdata[21:14];
    assign m_axis_tdata = {2'b00, w_rsp.row_pixels, w_rsp.unknown_op,
                           w_rsp.collision, w_rsp.pc_after};

    c8ie_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_req(w_in),
        .o_valid(w_qv), .i_ready(w_qr), .o_req(w_q)
    );

    c8ie_back #(.PROGRAM_START(PROGRAM_START)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_qv), .o_ready(w_qr), .i_req(w_q),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_rsp(w_rsp)
    );
endmodule

// File: sv/c8ie_checker.sv
// ----------------------------------------------------------------------------
// c8ie_checker
// Port-level checks on the execute block.
// ----------------------------------------------------------------------------
module c8ie_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[12] && m_axis_tdata[13]))
        else $error("collision and unknown together");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result after reset");
    a_rdy: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");
endmodule

bind chip8_instruction_execute c8ie_checker u_chk (
    .i_clk, .i_rst_n, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
